// ===== design/i2c_bit_level_master_top_macros.svh =====
// Assertion macros used by the I2C bit-level master top.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_RESET(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("reset assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_RESET(label, clk, prop)
`endif
`endif

// ===== design/i2cm_pkg.sv =====
// Package: types, codes and helpers for the I2C bit-level master.
`timescale 1ns / 1ps
package i2cm_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int REG_W           = 16;
   localparam int ADDR_W          = 4;

   localparam logic [REG_W-1:0] SETUP_RESET   = 16'd5;
   localparam logic [REG_W-1:0] BIT_HALF_RESET = 16'd1;
   localparam logic [REG_W-1:0] ACK_TO_RESET  = 16'd10000;

   typedef enum logic [1:0] {
      CSR_SETUP    = 2'd0,
      CSR_BIT_HALF = 2'd1,
      CSR_ACK_TO   = 2'd2,
      CSR_NONE     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_WAIT  = 3'd5,
      OP_ACK   = 3'd6,
      OP_NACK  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_PREP = 4'd1,
      PH_ST_HIGH = 4'd2,
      PH_ST_LOW  = 4'd3,
      PH_SP_PREP = 4'd4,
      PH_SP_HIGH = 4'd5,
      PH_SP_REL  = 4'd6,
      PH_AK_PREP = 4'd7,
      PH_AK_HIGH = 4'd8,
      PH_WR_LOW  = 4'd9,
      PH_WR_HIGH = 4'd10,
      PH_RD_LOW  = 4'd11,
      PH_RD_HIGH = 4'd12,
      PH_WA_PREP = 4'd13,
      PH_WA_HIGH = 4'd14
   } phase_type;

   typedef struct packed {
      logic [REG_W-1:0] setup_ticks;
      logic [REG_W-1:0] bit_half_ticks;
      logic [REG_W-1:0] ack_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] tx_byte;
      logic       nack_after_read;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       rejected;
      logic       timed_out;
      logic       nack_seen;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_drive;
      logic       sda_out;
      logic       scl_out;
   } result_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drv;
   } lines_type;

   // line levels on entry to a phase
   function automatic lines_type enter_lines(phase_type ph, logic held, logic msb,
                                             logic sda_cur);
      lines_type l;
      unique case (ph)
         PH_ST_PREP: l = '{1'b0, 1'b1, 1'b1};
         PH_ST_HIGH: l = '{1'b1, 1'b1, 1'b1};
         PH_ST_LOW:  l = '{1'b1, 1'b0, 1'b1};
         PH_SP_PREP: l = '{1'b0, 1'b0, 1'b1};
         PH_SP_HIGH: l = '{1'b1, 1'b0, 1'b1};
         PH_SP_REL:  l = '{1'b1, 1'b1, 1'b1};
         PH_AK_PREP: l = '{1'b0, held, 1'b1};
         PH_AK_HIGH: l = '{1'b1, held, 1'b1};
         PH_WR_LOW:  l = '{1'b0, msb, 1'b1};
         PH_WR_HIGH: l = '{1'b1, sda_cur, 1'b1};
         PH_RD_LOW:  l = '{1'b0, 1'b1, 1'b0};
         PH_RD_HIGH: l = '{1'b1, 1'b1, 1'b0};
         PH_WA_PREP: l = '{1'b0, 1'b1, 1'b0};
         PH_WA_HIGH: l = '{1'b1, 1'b1, 1'b0};
         default:    l = '{1'b1, 1'b1, 1'b0};
      endcase
      return l;
   endfunction

endpackage

// ===== design/i2cm_csr.sv =====
// Configuration registers of the I2C bit-level master on an APB-style port.
`timescale 1ns / 1ps
module i2cm_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [i2cm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output i2cm_pkg::cfg_type          cfg
);

   i2cm_pkg::cfg_type       cfg_ff, cfg_in;
   i2cm_pkg::csr_index_type idx;
   logic                    wr_en;

   assign idx   = i2cm_pkg::csr_index_type'(csr_paddr[3:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            i2cm_pkg::CSR_SETUP:    cfg_in.setup_ticks       = csr_pwdata[15:0];
            i2cm_pkg::CSR_BIT_HALF: cfg_in.bit_half_ticks    = csr_pwdata[15:0];
            i2cm_pkg::CSR_ACK_TO:   cfg_in.ack_timeout_ticks = csr_pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks       <= i2cm_pkg::SETUP_RESET;
         cfg_ff.bit_half_ticks    <= i2cm_pkg::BIT_HALF_RESET;
         cfg_ff.ack_timeout_ticks <= i2cm_pkg::ACK_TO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         i2cm_pkg::CSR_SETUP:    csr_prdata = {16'd0, cfg_ff.setup_ticks};
         i2cm_pkg::CSR_BIT_HALF: csr_prdata = {16'd0, cfg_ff.bit_half_ticks};
         i2cm_pkg::CSR_ACK_TO:   csr_prdata = {16'd0, cfg_ff.ack_timeout_ticks};
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== design/i2cm_engine.sv =====
// Bus sequencer state and per-tick next-state logic of the I2C master.
`timescale 1ns / 1ps
module i2cm_engine #(
   parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  i2cm_pkg::item_type   item,
   input  i2cm_pkg::cfg_type    cfg,
   output i2cm_pkg::result_type res
);

   localparam int CMP_W = (COUNT_WIDTH > i2cm_pkg::REG_W) ? COUNT_WIDTH : i2cm_pkg::REG_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   i2cm_pkg::phase_type    phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [3:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   scl_ff, scl_in, sda_ff, sda_in_nx, drv_ff, drv_in;
   logic                   held_ff, held_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   nack_ff, nack_in;
   logic                   pend_ff, pend_in;

   logic                   busy, done, tflag, ent;
   i2cm_pkg::phase_type    ent_ph;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [CMP_W-1:0]       cnt_x, dur_x;
   logic                   phase_end;
   i2cm_pkg::lines_type    ln;

   assign busy    = (phase_ff != i2cm_pkg::PH_IDLE);
   assign cnt_inc = (tick_ff == CNT_MAX) ? tick_ff : tick_ff + 1'b1;
   assign cnt_x   = CMP_W'(cnt_inc);

   always_comb begin
      unique case (phase_ff)
         i2cm_pkg::PH_ST_HIGH, i2cm_pkg::PH_ST_LOW, i2cm_pkg::PH_SP_HIGH,
         i2cm_pkg::PH_SP_REL, i2cm_pkg::PH_AK_HIGH:
            dur_x = CMP_W'(cfg.setup_ticks);
         i2cm_pkg::PH_WR_LOW, i2cm_pkg::PH_WR_HIGH, i2cm_pkg::PH_RD_LOW,
         i2cm_pkg::PH_RD_HIGH:
            dur_x = CMP_W'(cfg.bit_half_ticks);
         default:
            dur_x = CMP_W'(1);
      endcase
   end

   assign phase_end = (cnt_x >= dur_x) || (cnt_inc == CNT_MAX);

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      scl_in    = scl_ff;
      sda_in_nx = sda_ff;
      drv_in    = drv_ff;
      held_in   = held_ff;
      rx_in     = rx_ff;
      nack_in   = nack_ff;
      pend_in   = pend_ff;
      done      = 1'b0;
      tflag     = 1'b0;
      ent       = 1'b0;
      ent_ph    = i2cm_pkg::PH_IDLE;
      ln        = '{scl_ff, sda_ff, drv_ff};

      if (busy) begin
         tick_in = cnt_inc;
         if (phase_ff == i2cm_pkg::PH_WA_HIGH) begin
            if (!item.sda_in) begin
               nack_in = 1'b0;
               done    = 1'b1;
               ln      = '{1'b0, 1'b1, 1'b0};
            end else if (cnt_x >= CMP_W'(cfg.ack_timeout_ticks) || cnt_inc == CNT_MAX) begin
               nack_in = 1'b1;
               pend_in = 1'b1;
               ent     = 1'b1;
               ent_ph  = i2cm_pkg::PH_SP_PREP;
            end
         end else if (phase_end) begin
            unique case (phase_ff)
               i2cm_pkg::PH_ST_PREP: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST_HIGH; end
               i2cm_pkg::PH_ST_HIGH: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST_LOW; end
               i2cm_pkg::PH_ST_LOW: begin
                  done = 1'b1;
                  ln   = '{1'b0, 1'b0, 1'b1};
               end
               i2cm_pkg::PH_SP_PREP: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_SP_HIGH; end
               i2cm_pkg::PH_SP_HIGH: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_SP_REL; end
               i2cm_pkg::PH_SP_REL: begin
                  done    = 1'b1;
                  ln      = '{1'b1, 1'b1, 1'b1};
                  tflag   = pend_ff;
                  pend_in = 1'b0;
               end
               i2cm_pkg::PH_AK_PREP: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_AK_HIGH; end
               i2cm_pkg::PH_AK_HIGH: begin
                  done = 1'b1;
                  ln   = '{1'b0, held_ff, 1'b1};
               end
               i2cm_pkg::PH_WR_LOW: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_WR_HIGH; end
               i2cm_pkg::PH_WR_HIGH: begin
                  bit_in   = bit_ff + 4'd1;
                  shift_in = {shift_ff[6:0], 1'b0};
                  if (bit_in >= 4'd8) begin
                     done = 1'b1;
                     ln   = '{1'b0, sda_ff, 1'b1};
                  end else begin
                     ent    = 1'b1;
                     ent_ph = i2cm_pkg::PH_WR_LOW;
                  end
               end
               i2cm_pkg::PH_RD_LOW: begin
                  shift_in = {shift_ff[6:0], item.sda_in};
                  bit_in   = bit_ff + 4'd1;
                  ent      = 1'b1;
                  ent_ph   = i2cm_pkg::PH_RD_HIGH;
               end
               i2cm_pkg::PH_RD_HIGH: begin
                  if (bit_ff >= 4'd8) begin
                     rx_in  = shift_ff;
                     ent    = 1'b1;
                     ent_ph = i2cm_pkg::PH_AK_PREP;
                  end else begin
                     ent    = 1'b1;
                     ent_ph = i2cm_pkg::PH_RD_LOW;
                  end
               end
               i2cm_pkg::PH_WA_PREP: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_WA_HIGH; end
               default: phase_in = i2cm_pkg::PH_IDLE;
            endcase
         end
      end else begin
         unique case (item.operation)
            i2cm_pkg::OP_START: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_ST_PREP; end
            i2cm_pkg::OP_STOP: begin
               pend_in = 1'b0;
               ent     = 1'b1;
               ent_ph  = i2cm_pkg::PH_SP_PREP;
            end
            i2cm_pkg::OP_WRITE: begin
               shift_in = item.tx_byte;
               bit_in   = 4'd0;
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_WR_LOW;
            end
            i2cm_pkg::OP_READ: begin
               shift_in = 8'd0;
               bit_in   = 4'd0;
               held_in  = item.nack_after_read;
               ent      = 1'b1;
               ent_ph   = i2cm_pkg::PH_RD_LOW;
            end
            i2cm_pkg::OP_WAIT: begin ent = 1'b1; ent_ph = i2cm_pkg::PH_WA_PREP; end
            i2cm_pkg::OP_ACK: begin
               held_in = 1'b0;
               ent     = 1'b1;
               ent_ph  = i2cm_pkg::PH_AK_PREP;
            end
            i2cm_pkg::OP_NACK: begin
               held_in = 1'b1;
               ent     = 1'b1;
               ent_ph  = i2cm_pkg::PH_AK_PREP;
            end
            default: ent = 1'b0;
         endcase
      end

      if (ent) begin
         phase_in = ent_ph;
         tick_in  = '0;
         ln       = i2cm_pkg::enter_lines(ent_ph, held_in, shift_in[7], sda_ff);
      end
      if (done) begin
         phase_in = i2cm_pkg::PH_IDLE;
         tick_in  = '0;
      end
      scl_in    = ln.scl;
      sda_in_nx = ln.sda;
      drv_in    = ln.drv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cm_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drv_ff   <= 1'b0;
         held_ff  <= 1'b0;
         rx_ff    <= 8'd0;
         nack_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_nx;
         drv_ff   <= drv_in;
         held_ff  <= held_in;
         rx_ff    <= rx_in;
         nack_ff  <= nack_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      res.scl_out   = scl_in;
      res.sda_out   = sda_in_nx;
      res.sda_drive = drv_in;
      res.busy_res  = (phase_in != i2cm_pkg::PH_IDLE);
      res.done_res  = done;
      res.rx_byte   = rx_in;
      res.nack_seen = nack_in;
      res.timed_out = tflag;
      res.rejected  = busy && (item.operation != i2cm_pkg::OP_TICK);
   end

endmodule

// ===== design/i2c_bit_level_master_top.sv =====
// A request beat is held in the input register from its accepting edge; the sequencer
// step and the result register load happen together when that beat advances, which
// waits while the result register holds an untaken beat; the result beat is then offered.
// Throughput: one beat per cycle, limited only by the result side taking beats.
// Reset (synchronous) idles the sequencer, releases SCL and SDA, empties both
// registers and loads setup 5, bit half 1 and ack timeout 10000 ticks.
`timescale 1ns / 1ps
`include "i2c_bit_level_master_top_macros.svh"
module i2c_bit_level_master_top #(
   parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // tx_byte[7:0], nack_after_read, sda_in, zeros
   input  logic [2:0]                  req_tuser,  // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte[7:0], nack_seen,
   // timed_out, rejected
   output logic [15:0]                 rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [i2cm_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   i2cm_pkg::cfg_type    cfg;
   i2cm_pkg::item_type   item_ff, item_in;
   i2cm_pkg::result_type res, res_ff;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 adv, take_in;

   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign adv        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign take_in    = req_tvalid && req_tready;

   always_comb begin
      item_in.operation       = i2cm_pkg::op_type'(req_tuser);
      item_in.tx_byte         = req_tdata[7:0];
      item_in.nack_after_read = req_tdata[8];
      item_in.sda_in          = req_tdata[9];
      in_valid_in  = take_in || (in_valid_ff && !adv);
      out_valid_in = adv || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         item_ff <= item_in;
      end
      if (adv) begin
         res_ff <= res;
      end
   end

   i2cm_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (adv),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_ff.rejected, res_ff.timed_out, res_ff.nack_seen,
                        res_ff.rx_byte, res_ff.done_res, res_ff.busy_res,
                        res_ff.sda_drive, res_ff.sda_out, res_ff.scl_out};

   // a beat moved into the result register is offered next cycle
   `ASSERT_PROP(a_adv_offers, clock, reset, adv |=> out_valid_ff)
   // a held input beat is never overwritten by a new one
   `ASSERT_PROP(a_no_overrun, clock, reset, !(take_in && in_valid_ff && !adv))
   // a finished command leaves the sequencer idle in the same result
   `ASSERT_PROP(a_done_idle, clock, reset, (adv && res.done_res) |-> !res.busy_res)
   // reset empties both registers
   `ASSERT_RESET(a_reset_empty, clock, reset |=> (!in_valid_ff && !out_valid_ff))

endmodule
